[design/trp_pkg.sv]
// Shared types and constants for the tablet report to pointer events unit.
// Holds the controller/datapath command and status structs and result codes.
// No dependencies.
`default_nettype none

package trp_pkg;

	localparam int RAW_W      = 17;
	localparam int COORD_W    = 12;
	localparam int SCALE_W    = 16;
	localparam int CODE_W     = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	// Restoring divider step counts: 65536 / scale, then the low quotient bits.
	localparam int RCP_STEPS = 17;
	localparam int QUO_STEPS = COORD_W;
	localparam int CNT_W     = 5;

	// Result kinds
	localparam logic [1:0] KIND_POS = 2'd0;
	localparam logic [1:0] KIND_BTN = 2'd1;
	localparam logic [1:0] KIND_ERR = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_X_SCALE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_Y_SCALE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SCR_X_MAX = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SCR_Y_MAX = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BTN_ORDER = 3'd6;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_MUL,
		OP_RCP,
		OP_CHK,
		OP_QUO
	} lane_op_t;

	typedef struct packed {
		lane_op_t   op;
		logic       res_load;
		logic [1:0] res_kind;
		logic [1:0] res_which;
		logic       res_last;
		logic       commit;
	} trp_cmd_t;

	typedef struct packed {
		logic       disabled;
		logic       mapped;
		logic       hb;
		logic       bad;
		logic [2:0] diff;
	} trp_status_t;

endpackage

`default_nettype wire

[design/trp_lane.sv]
// One coordinate lane: offset, screen-maximum multiply, reciprocal and quotient division.
// Sequenced by lane_op_t commands; depends on trp_pkg.
`default_nettype none

module trp_lane import trp_pkg::*; (
	input  wire                       clk,
	input  wire lane_op_t             op,
	input  wire logic signed [RAW_W-1:0] raw,
	input  wire logic                 map_en,
	input  wire logic                 zero_above,
	input  wire logic [SCALE_W-1:0]   scale,
	input  wire logic signed [RAW_W-1:0] offset,
	input  wire logic [COORD_W-1:0]   smax,
	output logic [COORD_W-1:0]        coord
);

	logic signed [RAW_W-1:0] v_q;
	logic                    map_q;
	logic signed [30:0]      num_q;
	logic [16:0]             rem_q;
	logic [16:0]             dvd_q;
	logic [16:0]             rcp_q;
	logic [COORD_W-1:0]      quo_q;
	logic                    neg_q;
	logic                    sat_q;

	logic signed [RAW_W:0]   dif;
	logic signed [COORD_W:0] smax_s;
	logic signed [30:0]      prod;
	logic [16:0]             scale_eff;
	logic [16:0]             dsor;
	logic [17:0]             trial;
	logic                    ge;
	logic [17:0]             trial_nx;
	logic [16:0]             top_bits;

	assign dif    = 18'(v_q) - 18'(offset);
	assign smax_s = $signed({1'b0, smax});
	assign prod   = 31'(dif) * 31'(smax_s);

	// A zero scale acts as one
	assign scale_eff = (scale == '0) ? 17'd1 : {1'b0, scale};
	assign dsor      = (op == OP_RCP) ? scale_eff : rcp_q;
	assign trial     = {rem_q, dvd_q[16]};
	assign ge        = trial >= {1'b0, dsor};
	assign trial_nx  = ge ? (trial - {1'b0, dsor}) : trial;
	assign top_bits  = num_q[28:12];

	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				v_q   <= raw;
				map_q <= map_en;
			end
			OP_MUL: begin
				num_q <= prod;
				rem_q <= '0;
				dvd_q <= 17'h10000;
				rcp_q <= '0;
			end
			OP_RCP: begin
				rem_q <= trial_nx[16:0];
				dvd_q <= {dvd_q[15:0], 1'b0};
				rcp_q <= {rcp_q[15:0], ge};
			end
			OP_CHK: begin
				// Quotient of 4096 or more clamps anyway; divide only the low bits
				neg_q <= num_q[30];
				sat_q <= top_bits >= rcp_q;
				rem_q <= top_bits;
				dvd_q <= {num_q[11:0], 5'b0};
				quo_q <= '0;
			end
			OP_QUO: begin
				rem_q <= trial_nx[16:0];
				dvd_q <= {dvd_q[15:0], 1'b0};
				quo_q <= {quo_q[COORD_W-2:0], ge};
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		if (map_q) begin
			if (neg_q)
				coord = '0;
			else if (sat_q || (quo_q > smax))
				coord = smax;
			else
				coord = quo_q;
		end else begin
			if (v_q < 0)
				coord = '0;
			else if (v_q > $signed({5'b0, smax}))
				coord = zero_above ? '0 : smax;
			else
				coord = v_q[COORD_W-1:0];
		end
	end

endmodule

`default_nettype wire

[design/trp_dp.sv]
// Datapath: configuration registers, item and button state, two coordinate
// lanes and the result registers. Depends on trp_pkg and trp_lane.
`default_nettype none

module trp_dp import trp_pkg::*; (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_we,
	input  wire logic [CFG_IDX_W-1:0]    cfg_idx,
	input  wire logic [CFG_DATA_W-1:0]   cfg_data,
	input  wire                          has_buttons,
	input  wire logic [CODE_W-1:0]       button_code,
	input  wire logic signed [RAW_W-1:0] x_raw,
	input  wire logic signed [RAW_W-1:0] y_raw,
	input  wire trp_cmd_t                cmd,
	output trp_status_t                  st,
	output logic [1:0]                   kind,
	output logic [COORD_W-1:0]           cursor_x,
	output logic [COORD_W-1:0]           cursor_y,
	output logic [1:0]                   which_button,
	output logic                         pressed,
	output logic                         last
);

	localparam logic [1:0] ORD_LMR_124 = 2'd0;
	localparam logic [1:0] ORD_LMR_421 = 2'd1;
	localparam logic [1:0] ORD_LMR_842 = 2'd2;

	logic [SCALE_W-1:0]          x_scale_q, y_scale_q;
	logic signed [RAW_W-1:0]     x_off_q, y_off_q;
	logic [COORD_W-1:0]          sx_max_q, sy_max_q;
	logic [1:0]                  order_q;

	logic                        hb_q;
	logic [CODE_W-1:0]           code_q;
	logic [2:0]                  held_q;
	logic                        dis_q;

	logic [1:0]                  kind_q;
	logic [COORD_W-1:0]          cx_q, cy_q;
	logic [1:0]                  which_q;
	logic                        pressed_q;
	logic                        last_q;

	logic [COORD_W-1:0]          x_coord, y_coord;
	logic [3:0]                  lb, mb, rb;
	logic [CODE_W-1:0]           code_c;
	logic [2:0]                  want;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_scale_q <= 16'd1;
			y_scale_q <= 16'd1;
			x_off_q   <= 17'sd8;
			y_off_q   <= 17'sd8;
			sx_max_q  <= 12'd511;
			sy_max_q  <= 12'd482;
			order_q   <= 2'd3;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_X_SCALE:   x_scale_q <= cfg_data[SCALE_W-1:0];
				REG_Y_SCALE:   y_scale_q <= cfg_data[SCALE_W-1:0];
				REG_X_OFFSET:  x_off_q   <= $signed(cfg_data);
				REG_Y_OFFSET:  y_off_q   <= $signed(cfg_data);
				REG_SCR_X_MAX: sx_max_q  <= cfg_data[COORD_W-1:0];
				REG_SCR_Y_MAX: sy_max_q  <= cfg_data[COORD_W-1:0];
				REG_BTN_ORDER: order_q   <= cfg_data[1:0];
				default: begin
				end
			endcase
		end
	end

	trp_lane u_lane_x (
		.clk        (clk),
		.op         (cmd.op),
		.raw        (x_raw),
		.map_en     (has_buttons & button_code[4]),
		.zero_above (1'b0),
		.scale      (x_scale_q),
		.offset     (x_off_q),
		.smax       (sx_max_q),
		.coord      (x_coord)
	);

	// y above the screen drops to 0 only for button reports in screen units
	trp_lane u_lane_y (
		.clk        (clk),
		.op         (cmd.op),
		.raw        (y_raw),
		.map_en     (has_buttons & button_code[4]),
		.zero_above (hb_q & ~code_q[4]),
		.scale      (y_scale_q),
		.offset     (y_off_q),
		.smax       (sy_max_q),
		.coord      (y_coord)
	);

	always_comb begin
		case (order_q)
			ORD_LMR_124: begin lb = 4'd1; mb = 4'd2; rb = 4'd4; end
			ORD_LMR_421: begin lb = 4'd4; mb = 4'd2; rb = 4'd1; end
			ORD_LMR_842: begin lb = 4'd8; mb = 4'd4; rb = 4'd2; end
			default:     begin lb = 4'd2; mb = 4'd4; rb = 4'd8; end
		endcase
	end

	assign code_c  = code_q & ~8'h10;
	assign want[0] = |(code_c[3:0] & lb);
	assign want[1] = |(code_c[3:0] & mb);
	assign want[2] = |(code_c[3:0] & rb);

	assign st.disabled = dis_q;
	assign st.mapped   = hb_q & code_q[4];
	assign st.hb       = hb_q;
	assign st.bad      = |code_c[7:4];
	assign st.diff     = want ^ held_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			dis_q  <= 1'b0;
		end else if (cmd.commit && hb_q) begin
			if (st.bad)
				dis_q <= 1'b1;
			else
				held_q <= want;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD) begin
			hb_q   <= has_buttons;
			code_q <= button_code;
		end
		if (cmd.res_load) begin
			kind_q  <= cmd.res_kind;
			which_q <= cmd.res_which;
			last_q  <= cmd.res_last;
			case (cmd.res_kind)
				KIND_POS: begin
					cx_q      <= x_coord;
					cy_q      <= y_coord;
					pressed_q <= 1'b0;
				end
				KIND_BTN: begin
					// held already carries the new button state
					cx_q      <= x_coord;
					cy_q      <= y_coord;
					pressed_q <= held_q[cmd.res_which];
				end
				default: begin
					cx_q      <= '0;
					cy_q      <= '0;
					pressed_q <= 1'b0;
				end
			endcase
		end
	end

	assign kind         = kind_q;
	assign cursor_x     = cx_q;
	assign cursor_y     = cy_q;
	assign which_button = which_q;
	assign pressed      = pressed_q;
	assign last         = last_q;

endmodule

`default_nettype wire

[design/trp_ctrl.sv]
// Controller: sequences the lane divider steps and the emitted results.
// Depends on trp_pkg.
`default_nettype none

module trp_ctrl import trp_pkg::*; (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  wire              out_stall,
	input  wire trp_status_t st,
	output trp_cmd_t         cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_RCP,
		S_CHK,
		S_QUO,
		S_POS,
		S_OUT
	} state_t;

	state_t           state_q, state_nx;
	logic [CNT_W-1:0] cnt_q;
	logic [2:0]       pend_q;
	logic             err_q;

	logic [2:0]       pick;
	logic [1:0]       pick_idx;
	logic [2:0]       pos_pend;
	logic             pos_err;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);

	assign pick     = pend_q[0] ? 3'b001 : (pend_q[1] ? 3'b010 : 3'b100);
	assign pick_idx = pend_q[0] ? 2'd0 : (pend_q[1] ? 2'd1 : 2'd2);
	assign pos_err  = st.hb & st.bad;
	assign pos_pend = (st.hb & ~st.bad) ? st.diff : 3'b000;

	always_comb begin
		cmd          = '0;
		cmd.op       = OP_NONE;
		state_nx     = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (st.disabled) begin
						cmd.res_load = 1'b1;
						cmd.res_kind = KIND_ERR;
						cmd.res_last = 1'b1;
						state_nx     = S_OUT;
					end else begin
						cmd.op   = OP_LOAD;
						state_nx = S_MUL;
					end
				end
			end
			S_MUL: begin
				cmd.op   = OP_MUL;
				state_nx = st.mapped ? S_RCP : S_POS;
			end
			S_RCP: begin
				cmd.op = OP_RCP;
				if (cnt_q == '0)
					state_nx = S_CHK;
			end
			S_CHK: begin
				cmd.op   = OP_CHK;
				state_nx = S_QUO;
			end
			S_QUO: begin
				cmd.op = OP_QUO;
				if (cnt_q == '0)
					state_nx = S_POS;
			end
			S_POS: begin
				cmd.res_load = 1'b1;
				cmd.res_kind = KIND_POS;
				cmd.res_last = ~pos_err & (pos_pend == 3'b000);
				cmd.commit   = 1'b1;
				state_nx     = S_OUT;
			end
			S_OUT: begin
				if (!out_stall) begin
					if (err_q) begin
						cmd.res_load = 1'b1;
						cmd.res_kind = KIND_ERR;
						cmd.res_last = 1'b1;
					end else if (pend_q != 3'b000) begin
						cmd.res_load  = 1'b1;
						cmd.res_kind  = KIND_BTN;
						cmd.res_which = pick_idx;
						cmd.res_last  = ((pend_q & ~pick) == 3'b000);
					end else begin
						state_nx = S_IDLE;
					end
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			pend_q  <= '0;
			err_q   <= 1'b0;
		end else begin
			state_q <= state_nx;
			case (state_q)
				S_IDLE: begin
					pend_q <= '0;
					err_q  <= 1'b0;
				end
				S_MUL: cnt_q <= CNT_W'(RCP_STEPS - 1);
				S_RCP: begin
					if (cnt_q == '0)
						cnt_q <= CNT_W'(QUO_STEPS - 1);
					else
						cnt_q <= cnt_q - 1'b1;
				end
				S_QUO: cnt_q <= cnt_q - 1'b1;
				S_POS: begin
					pend_q <= pos_pend;
					err_q  <= pos_err;
				end
				S_OUT: begin
					// drop the event just handed over
					if (!out_stall) begin
						if (err_q)
							err_q <= 1'b0;
						else
							pend_q <= pend_q & ~pick;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[design/tablet_report_to_pointer_events_unit.sv]
// Tablet report to pointer events: top level joining controller and datapath.
// An item is taken only when the block is idle. A plain report or a button
// report in screen units goes from load and multiply to its position result; a
// report in tablet units also runs the per-coordinate restoring divider (17 steps
// for 65536 / scale, 12 steps for the clamped quotient, x and y in parallel).
// Each result then stays up until taken, up to 4 per item, and the block is idle
// again in the cycle after the last one is taken. Once a bad button code is seen
// every later item yields a single error result on the cycle after it is taken.
`default_nettype none

module tablet_report_to_pointer_events_unit import trp_pkg::*; (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_we,
	input  wire logic [CFG_IDX_W-1:0]    cfg_idx,
	input  wire logic [CFG_DATA_W-1:0]   cfg_data,
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire                          has_buttons,
	input  wire logic [CODE_W-1:0]       button_code,
	input  wire logic signed [RAW_W-1:0] x_raw,
	input  wire logic signed [RAW_W-1:0] y_raw,
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic [1:0]                   kind,
	output logic [COORD_W-1:0]           cursor_x,
	output logic [COORD_W-1:0]           cursor_y,
	output logic [1:0]                   which_button,
	output logic                         pressed,
	output logic                         last
);

	trp_cmd_t    cmd;
	trp_status_t st;

	trp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.st        (st),
		.cmd       (cmd)
	);

	trp_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_data     (cfg_data),
		.has_buttons  (has_buttons),
		.button_code  (button_code),
		.x_raw        (x_raw),
		.y_raw        (y_raw),
		.cmd          (cmd),
		.st           (st),
		.kind         (kind),
		.cursor_x     (cursor_x),
		.cursor_y     (cursor_y),
		.which_button (which_button),
		.pressed      (pressed),
		.last         (last)
	);

`ifndef SYNTHESIS
	a_idle_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !out_valid)
		else $error("item taken while a result is still pending");

	a_disabled_error: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && st.disabled) |=>
		(out_valid && kind == KIND_ERR && last))
		else $error("disabled block did not answer with a single error");

	a_disabled_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		st.disabled |=> st.disabled)
		else $error("disabled flag cleared");

	a_error_blank: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == KIND_ERR) |->
		(cursor_x == '0 && cursor_y == '0 && which_button == '0 && !pressed))
		else $error("error result carries nonzero fields");
`endif

endmodule

`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 100ps
// Testbench for tablet_report_to_pointer_events_unit: directed table, then random reports.
// Checks each result against an in-bench predictor of positions, button events and errors.
// Depends on trp_pkg and the unit's RTL only.

module tb_top;
	import trp_pkg::*;

	localparam int CLK_HALF      = 5;
	localparam int RESET_CYCLES  = 6;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 8;
	localparam int IDLE_PCT      = 12;
	localparam int N_PHASES      = 6;
	localparam int PHASE_ITEMS   = 55;
	localparam int TAIL_ITEMS    = 16;
	localparam int HOLD_AT       = 60;
	localparam int HOLD_CYCLES   = 300;
	localparam int QUIET_FROM    = 200;
	localparam int QUIET_TO      = 260;
	localparam int MAX_REPORTS   = 30;
	localparam int N_ROWS        = 18;

	localparam logic [RAW_W-1:0] RAW_MIN  = 17'h10000;
	localparam logic [RAW_W-1:0] RAW_MAX  = 17'h0FFFF;
	localparam logic [RAW_W-1:0] RAW_NEG1 = 17'h1FFFF;

	// Code bits for left/middle/right
	localparam logic [1:0] ORDER_124 = 2'd0;
	localparam logic [1:0] ORDER_421 = 2'd1;
	localparam logic [1:0] ORDER_842 = 2'd2;
	localparam logic [1:0] ORDER_248 = 2'd3;

	typedef struct packed {
		logic [1:0]         kind;
		logic [COORD_W-1:0] cx;
		logic [COORD_W-1:0] cy;
		logic [1:0]         which;
		logic               pressed;
		logic               last;
	} pointer_evt_t;

	typedef struct packed {
		logic               hb;
		logic [CODE_W-1:0]  code;
		logic [RAW_W-1:0]   x;
		logic [RAW_W-1:0]   y;
		logic               typed;
		logic [COORD_W-1:0] tx;
		logic [COORD_W-1:0] ty;
	} report_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic has_buttons;
	logic [CODE_W-1:0] button_code;
	logic signed [RAW_W-1:0] x_raw;
	logic signed [RAW_W-1:0] y_raw;
	logic out_valid;
	logic out_stall;
	logic [1:0] kind;
	logic [COORD_W-1:0] cursor_x;
	logic [COORD_W-1:0] cursor_y;
	logic [1:0] which_button;
	logic pressed;
	logic last;

	// Mirror of the unit's registers and state
	logic [SCALE_W-1:0] shadow_x_scale, shadow_y_scale;
	logic signed [RAW_W-1:0] shadow_x_off, shadow_y_off;
	logic [COORD_W-1:0] shadow_x_max, shadow_y_max;
	logic [1:0] shadow_order;
	logic [2:0] held_buttons;
	logic unit_disabled;

	pointer_evt_t pending_pointer_events[$];
	report_row_t directed_rows [N_ROWS];
	int unsigned fail_count = 0;
	int unsigned accepted_items = 0;
	int unsigned cycle_count = 0;

	tablet_report_to_pointer_events_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.has_buttons(has_buttons),
		.button_code(button_code),
		.x_raw(x_raw),
		.y_raw(y_raw),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.cursor_x(cursor_x),
		.cursor_y(cursor_y),
		.which_button(which_button),
		.pressed(pressed),
		.last(last)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("tablet_report_to_pointer_events_unit test failed");
		$finish;
	end

	function automatic bit no_idle_window();
		return accepted_items >= QUIET_FROM && accepted_items < QUIET_TO;
	endfunction

	// Tablet units to screen units; division truncates toward zero
	function automatic longint tablet_to_screen(logic signed [RAW_W-1:0] v,
			logic signed [RAW_W-1:0] off, logic [COORD_W-1:0] smax,
			logic [SCALE_W-1:0] scale);
		longint sc;
		longint dv;
		sc = (scale == '0) ? 64'sd1 : longint'(scale);
		dv = 64'sd65536 / sc;
		return ((longint'(v) - longint'(off)) * longint'(smax)) / dv;
	endfunction

	function automatic logic [COORD_W-1:0] clamp_coord(longint v, logic [COORD_W-1:0] hi);
		if (v < 0)
			return '0;
		if (v > longint'(hi))
			return hi;
		return v[COORD_W-1:0];
	endfunction

	// Queue the results one report causes; typed rows force the cursor position
	function automatic void predict_report(logic hb, logic [CODE_W-1:0] code_in,
			logic signed [RAW_W-1:0] xr, logic signed [RAW_W-1:0] yr, logic typed,
			logic [COORD_W-1:0] tx, logic [COORD_W-1:0] ty);
		logic [CODE_W-1:0] code;
		longint xs, ys;
		logic [COORD_W-1:0] cx, cy;
		logic [3:0] lb, mb, rb;
		logic [2:0] want, diff;
		pointer_evt_t ev;
		int b;
		code = code_in;
		xs = xr;
		ys = yr;
		if (unit_disabled) begin
			ev = '0;
			ev.kind = KIND_ERR;
			ev.last = 1'b1;
			pending_pointer_events.push_back(ev);
			return;
		end
		if (hb) begin
			if (code[4]) begin
				code[4] = 1'b0;
				xs = tablet_to_screen(xr, shadow_x_off, shadow_x_max, shadow_x_scale);
				ys = tablet_to_screen(yr, shadow_y_off, shadow_y_max, shadow_y_scale);
			end else if (ys > longint'(shadow_y_max)) begin
				ys = 0;
			end
		end
		cx = clamp_coord(xs, shadow_x_max);
		cy = clamp_coord(ys, shadow_y_max);
		if (typed) begin
			cx = tx;
			cy = ty;
		end
		ev = '0;
		ev.kind = KIND_POS;
		ev.cx = cx;
		ev.cy = cy;
		pending_pointer_events.push_back(ev);
		if (hb) begin
			if (code > 8'd15) begin
				ev = '0;
				ev.kind = KIND_ERR;
				pending_pointer_events.push_back(ev);
				unit_disabled = 1'b1;
			end else begin
				case (shadow_order)
					ORDER_124: begin lb = 4'd1; mb = 4'd2; rb = 4'd4; end
					ORDER_421: begin lb = 4'd4; mb = 4'd2; rb = 4'd1; end
					ORDER_842: begin lb = 4'd8; mb = 4'd4; rb = 4'd2; end
					default: begin lb = 4'd2; mb = 4'd4; rb = 4'd8; end
				endcase
				want = {(code[3:0] & rb) != 4'd0, (code[3:0] & mb) != 4'd0,
					(code[3:0] & lb) != 4'd0};
				diff = want ^ held_buttons;
				for (b = 0; b < 3; b++) begin
					if (diff[b]) begin
						ev = '0;
						ev.kind = KIND_BTN;
						ev.cx = cx;
						ev.cy = cy;
						ev.which = b[1:0];
						ev.pressed = want[b];
						pending_pointer_events.push_back(ev);
					end
				end
				held_buttons = want;
			end
		end
		ev = pending_pointer_events[$];
		ev.last = 1'b1;
		pending_pointer_events[$] = ev;
	endfunction

	function automatic void check_field(string fname, logic [COORD_W-1:0] want,
			logic [COORD_W-1:0] got);
		if (got !== want) begin
			fail_count++;
			if (fail_count <= MAX_REPORTS)
				$display("%0t: %s expected %0d actual %0d", $time, fname, want, got);
		end
	endfunction

	always @(posedge clk) begin : result_check
		pointer_evt_t want_ev;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_pointer_events.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("%0t: no result expected, actual kind %0d x %0d y %0d",
						$time, kind, cursor_x, cursor_y);
			end else begin
				want_ev = pending_pointer_events.pop_front();
				check_field("kind", COORD_W'(want_ev.kind), COORD_W'(kind));
				check_field("cursor_x", want_ev.cx, cursor_x);
				check_field("cursor_y", want_ev.cy, cursor_y);
				check_field("which_button", COORD_W'(want_ev.which),
					COORD_W'(which_button));
				check_field("pressed", COORD_W'(want_ev.pressed), COORD_W'(pressed));
				check_field("last", COORD_W'(want_ev.last), COORD_W'(last));
			end
		end
	end

	// Result side: random stalls, one long hold-off to back the unit up
	initial begin : result_stall
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!hold_done && accepted_items >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (no_idle_window()) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after the item is taken
	task automatic send_report(input logic hb, input logic [CODE_W-1:0] code,
			input logic [RAW_W-1:0] xr, input logic [RAW_W-1:0] yr, input logic typed,
			input logic [COORD_W-1:0] tx, input logic [COORD_W-1:0] ty);
		while (!no_idle_window() && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		has_buttons <= hb;
		button_code <= code;
		x_raw <= xr;
		y_raw <= yr;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		accepted_items++;
		predict_report(hb, code, xr, yr, typed, tx, ty);
		@(negedge clk);
	endtask

	function automatic logic [RAW_W-1:0] pick_coord(logic [RAW_W-1:0] off);
		logic [31:0] r;
		r = $urandom;
		case (r[31:30])
			2'd0: return r[RAW_W-1:0];
			2'd1: return {4'd0, r[12:0]};
			2'd2: return off + {{4{r[12]}}, r[12:0]};
			default: begin
				case (r[1:0])
					2'd0: return RAW_MIN;
					2'd1: return RAW_MAX;
					2'd2: return '0;
					default: return RAW_NEG1;
				endcase
			end
		endcase
	endfunction

	// Well-formed reports keep the code valid; otherwise any code goes
	task automatic send_random_report(input bit well_formed);
		logic [31:0] r;
		logic hb;
		logic [CODE_W-1:0] code;
		r = $urandom;
		hb = (r[6:0] < 7'd96);
		if (hb && well_formed)
			code = {3'b000, r[11:7]};
		else
			code = r[19:12];
		send_report(hb, code, pick_coord(shadow_x_off), pick_coord(shadow_y_off),
			1'b0, '0, '0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(negedge clk);
	endtask

	// Unused upper data bits carry junk; the unit must drop them
	task automatic load_setting(input logic [SCALE_W-1:0] xs, input logic [SCALE_W-1:0] ys,
			input logic [RAW_W-1:0] xo, input logic [RAW_W-1:0] yo,
			input logic [COORD_W-1:0] xm, input logic [COORD_W-1:0] ym,
			input logic [1:0] ord);
		logic [31:0] junk;
		junk = $urandom;
		write_reg(REG_X_SCALE, {junk[0], xs});
		write_reg(REG_Y_SCALE, {junk[1], ys});
		write_reg(REG_X_OFFSET, xo);
		write_reg(REG_Y_OFFSET, yo);
		write_reg(REG_SCR_X_MAX, {junk[6:2], xm});
		write_reg(REG_SCR_Y_MAX, {junk[11:7], ym});
		write_reg(REG_BTN_ORDER, {junk[26:12], ord});
		cfg_we <= 1'b0;
		shadow_x_scale = xs;
		shadow_y_scale = ys;
		shadow_x_off = xo;
		shadow_y_off = yo;
		shadow_x_max = xm;
		shadow_y_max = ym;
		shadow_order = ord;
	endtask

	function automatic logic [SCALE_W-1:0] rand_scale();
		logic [31:0] r;
		r = $urandom;
		return (r[31:30] == 2'b00) ? r[15:0] : {11'd0, r[4:0]} + 16'd1;
	endfunction

	function automatic logic [COORD_W-1:0] rand_max();
		logic [31:0] r;
		r = $urandom;
		return r[31] ? r[11:0] : {2'b00, r[9:0]};
	endfunction

	function automatic logic [RAW_W-1:0] rand_raw();
		logic [31:0] r;
		r = $urandom;
		return r[RAW_W-1:0];
	endfunction

	// Wait out every expected result, then let the unit return to idle
	task automatic drain_results();
		while (pending_pointer_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin : stimulus
		int row;
		int phase;
		int n;
		logic [31:0] r;
		directed_rows = '{
			'{1'b0, 8'hFF, 17'd0, 17'd0, 1'b1, 12'd0, 12'd0},
			'{1'b0, 8'h00, RAW_MAX, RAW_MAX, 1'b1, 12'd511, 12'd482},
			'{1'b0, 8'h5A, RAW_MIN, RAW_MIN, 1'b1, 12'd0, 12'd0},
			'{1'b0, 8'hA5, 17'd100, 17'd483, 1'b1, 12'd100, 12'd482},
			'{1'b1, 8'h00, 17'd10, 17'd483, 1'b1, 12'd10, 12'd0},
			'{1'b1, 8'h00, 17'd511, 17'd482, 1'b1, 12'd511, 12'd482},
			'{1'b1, 8'h02, 17'd20, 17'd30, 1'b1, 12'd20, 12'd30},
			'{1'b1, 8'h0C, 17'd5, 17'd6, 1'b1, 12'd5, 12'd6},
			'{1'b1, 8'h0F, RAW_NEG1, RAW_NEG1, 1'b1, 12'd0, 12'd0},
			'{1'b1, 8'h01, 17'd1, 17'd2, 1'b1, 12'd1, 12'd2},
			'{1'b1, 8'h10, 17'd8, 17'd8, 1'b1, 12'd0, 12'd0},
			'{1'b1, 8'h1E, RAW_MAX, RAW_MAX, 1'b0, 12'd0, 12'd0},
			'{1'b1, 8'h10, RAW_MIN, RAW_MIN, 1'b1, 12'd0, 12'd0},
			'{1'b1, 8'h1F, 17'd40000, 17'd20000, 1'b0, 12'd0, 12'd0},
			'{1'b1, 8'h10, 17'd0, RAW_MAX, 1'b0, 12'd0, 12'd0},
			'{1'b1, 8'h00, RAW_MIN, RAW_MAX, 1'b1, 12'd0, 12'd0},
			'{1'b1, 8'h08, 17'd4095, 17'd0, 1'b1, 12'd511, 12'd0},
			'{1'b0, 8'h0F, 17'd300, 17'd400, 1'b1, 12'd300, 12'd400}
		};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		has_buttons = 1'b0;
		button_code = '0;
		x_raw = '0;
		y_raw = '0;
		shadow_x_scale = 16'd1;
		shadow_y_scale = 16'd1;
		shadow_x_off = 17'sd8;
		shadow_y_off = 17'sd8;
		shadow_x_max = 12'd511;
		shadow_y_max = 12'd482;
		shadow_order = ORDER_248;
		held_buttons = 3'b000;
		unit_disabled = 1'b0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed rows run on the reset register values
		for (row = 0; row < N_ROWS; row++)
			send_report(directed_rows[row].hb, directed_rows[row].code,
				directed_rows[row].x, directed_rows[row].y, directed_rows[row].typed,
				directed_rows[row].tx, directed_rows[row].ty);
		in_valid <= 1'b0;

		for (phase = 0; phase < N_PHASES; phase++) begin
			drain_results();
			r = $urandom;
			case (phase)
				0: load_setting(16'd0, 16'hFFFF, RAW_MIN, RAW_MAX, 12'd4095, 12'd0,
					ORDER_124);
				1: load_setting(16'hFFFF, 16'd0, RAW_MAX, RAW_MIN, 12'd0, 12'd4095,
					ORDER_421);
				2: load_setting(rand_scale(), rand_scale(), rand_raw(), rand_raw(),
					rand_max(), rand_max(), ORDER_842);
				3: load_setting(rand_scale(), rand_scale(), rand_raw(), rand_raw(),
					rand_max(), rand_max(), ORDER_248);
				default: load_setting(rand_scale(), rand_scale(), rand_raw(), rand_raw(),
					rand_max(), rand_max(), r[1:0]);
			endcase
			for (n = 0; n < PHASE_ITEMS; n++)
				send_random_report(1'b1);
			in_valid <= 1'b0;
		end

		// A bad code disables the unit for the rest of the run
		drain_results();
		r = $urandom;
		send_report(1'b1, {r[2:0] | 3'b001, r[7:3]}, pick_coord(shadow_x_off),
			pick_coord(shadow_y_off), 1'b0, '0, '0);
		for (n = 0; n < TAIL_ITEMS; n++)
			send_random_report(1'b0);
		in_valid <= 1'b0;
		drain_results();

		if (fail_count == 0)
			$display("tablet_report_to_pointer_events_unit test passed");
		else
			$display("tablet_report_to_pointer_events_unit test failed");
		$finish;
	end

endmodule
